FILE: design/mss_pkg.sv
`default_nettype none

package mss_pkg;

  // Fixed header size and message length limit of the slice format.
  localparam int unsigned HEADER_BYTES      = 20;
  localparam int unsigned MAX_MESSAGE_BYTES = 65535;

  // Reset values of the configuration registers.
  localparam logic [15:0] RESET_PAYLOAD = 16'd100;
  localparam logic [31:0] RESET_MARKER  = 32'hff11ddaa;

  // Restoring divider: one quotient bit per cycle over a 16-bit length.
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    CFG_MAX_PAYLOAD = 2'd0,
    CFG_MARKER      = 2'd1,
    CFG_FIRST_ID    = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  // Classified input byte, handed from the front to the back.
  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] len;
    logic        first;
    logic [15:0] slices;
    logic [15:0] tail;
  } cmd_t;

  // One tagged result byte.
  typedef struct packed {
    logic [7:0]  payload;
    logic [31:0] id;
    logic [15:0] slice_number;
    logic [15:0] slice_total;
    logic [16:0] slice_bytes;
    logic        slice_end;
    logic        message_end;
  } res_t;

  // Id counter load from the configuration port.
  typedef struct packed {
    logic        load;
    logic [31:0] value;
  } id_load_t;

endpackage

`default_nettype wire

FILE: design/message_slice_segmenter.sv
// Message slice segmenter: tags a byte stream of messages with slice headers.
//
// Input side is a queue write port: an input transaction completes when push
// is high and full is low. The first byte of a message carries
// first_of_message and message_length. Output side is a queue read port: the
// oldest result sits on the result ports while empty is low and is taken when
// pop is high. Configuration is a plain write port (cfg_write, cfg_index,
// cfg_data). The user must use it only while the block is idle; not enforced.
//
// A byte inside a message is written into the command queue and then, tagged,
// into the result queue; the block takes one such byte every cycle while full
// is low. The first byte of a message of nonzero length runs through a 16-step
// restoring divider (slice count and tail size), so the front holds full high
// until the divide is done and that byte is pushed into the command queue;
// bytes already queued keep draining meanwhile.
// Reset (rst, synchronous) empties both queues, clears the message state and
// the id counter, and loads the register reset values. When the receiver
// stalls, results pile up in the result queue, then the command queue, and
// then full rises; nothing is dropped.
`default_nettype none

module message_slice_segmenter #(
  parameter int unsigned CMD_DEPTH = 4,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  // input transactions
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic [15:0] message_length,
  input  logic        first_of_message,
  // result transactions
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  payload_byte,
  output logic [31:0] message_id,
  output logic [15:0] slice_number,
  output logic [15:0] slice_total,
  output logic [16:0] slice_bytes,
  output logic [31:0] marker_word,
  output logic        slice_end,
  output logic        message_end,
  // configuration writes
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mss_pkg::*;

  logic [15:0] max_slice_payload;
  logic [31:0] header_marker;
  logic [15:0] maxp;
  id_load_t    id_cfg;

  logic  cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t  cmd_in, cmd_out;
  logic  res_push, res_full;
  res_t  res_in, res_out;

  // Configuration registers; a size of zero behaves as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_slice_payload <= RESET_PAYLOAD;
      header_marker     <= RESET_MARKER;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MAX_PAYLOAD: max_slice_payload <= cfg_data[15:0];
        CFG_MARKER:      header_marker     <= cfg_data;
        default:         ;
      endcase
    end
  end

  assign maxp         = (max_slice_payload == '0) ? 16'd1 : max_slice_payload;
  assign id_cfg.load  = cfg_write && (cfg_index == CFG_FIRST_ID);
  assign id_cfg.value = cfg_data;

  // Front: accept and classify, divide on message start.
  mss_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .full             (full),
    .data_byte        (data_byte),
    .message_length   (message_length),
    .first_of_message (first_of_message),
    .maxp             (maxp),
    .q_push           (cmd_push),
    .q_data           (cmd_in),
    .q_full           (cmd_full)
  );

  // Decouple the divider from the tagging back end.
  mss_queue #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_out),
    .empty (cmd_empty)
  );

  // Back: hold message state, tag bytes, advance the id.
  mss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .maxp      (maxp),
    .id_cfg    (id_cfg),
    .res_push  (res_push),
    .res       (res_in),
    .res_full  (res_full)
  );

  // Result queue: parts the receiver's stalls from the back end.
  mss_queue #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign payload_byte = res_out.payload;
  assign message_id   = res_out.id;
  assign slice_number = res_out.slice_number;
  assign slice_total  = res_out.slice_total;
  assign slice_bytes  = res_out.slice_bytes;
  assign slice_end    = res_out.slice_end;
  assign message_end  = res_out.message_end;
  assign marker_word  = header_marker;

  // A message end always closes its slice.
  a_mend_closes_slice: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (!message_end || slice_end))
    else $error("message end without slice end");

  // The back end never writes a result into a full result queue.
  a_no_res_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue overflow");

  // The front never writes into a full command queue.
  a_no_cmd_overflow: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command queue overflow");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result pending after reset");

endmodule

`default_nettype wire

FILE: design/mss_queue.sv
`default_nettype none

// Small register-file queue. DEPTH must be a power of two, at least 2.
module mss_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = PW + 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/mss_front.sv
`default_nettype none

// Accept input bytes; on the start of a message of nonzero length, divide the
// length by the slice payload size before handing the byte on.
module mss_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic [15:0]        message_length,
  input  logic               first_of_message,
  input  logic [15:0]        maxp,
  output logic               q_push,
  output mss_pkg::cmd_t      q_data,
  input  logic               q_full
);
  import mss_pkg::*;

  front_state_t      state;
  front_state_t      state_next;
  logic [STEP_W-1:0] step;
  logic [15:0]       dvd;
  logic [15:0]       rem;
  logic [15:0]       div_maxp;
  logic [7:0]        hold_data;
  logic [15:0]       hold_len;

  logic        accept;
  logic        start_div;
  logic [15:0] len_sat;
  logic [16:0] rem_shift;
  logic        q_bit;
  logic [15:0] rem_step;
  cmd_t        direct;
  cmd_t        held;

  assign len_sat = (17'(message_length) > 17'(MAX_MESSAGE_BYTES)) ?
                   16'(MAX_MESSAGE_BYTES) : message_length;

  // One restoring step.
  assign rem_shift = {rem, dvd[15]};
  assign q_bit     = rem_shift >= {1'b0, div_maxp};
  assign rem_step  = q_bit ? 16'(rem_shift - {1'b0, div_maxp}) : rem_shift[15:0];

  always_comb begin
    state_next = state;
    unique case (state)
      FR_IDLE: if (start_div) state_next = FR_DIV;
      FR_DIV:  if (step == STEP_W'(DIV_STEPS - 1)) state_next = FR_PUSH;
      FR_PUSH: if (!q_full) state_next = FR_IDLE;
      default: state_next = FR_IDLE;
    endcase
  end

  always_comb begin
    full      = (state != FR_IDLE) || q_full;
    accept    = push && !full;
    start_div = accept && first_of_message && (len_sat != '0);

    direct.data   = data_byte;
    direct.len    = len_sat;
    direct.first  = first_of_message;
    direct.slices = '0;
    direct.tail   = '0;

    held.data   = hold_data;
    held.len    = hold_len;
    held.first  = 1'b1;
    held.slices = dvd + 16'(rem != '0);
    held.tail   = (rem == '0) ? div_maxp : rem;

    if (state == FR_PUSH) begin
      q_push = !q_full;
      q_data = held;
    end else begin
      q_push = accept && !start_div;
      q_data = direct;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (state == FR_DIV) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end
    end
  end

  // Divider datapath: load the dividend, then shift a quotient bit in per step.
  always_ff @(posedge clk) begin
    if (start_div) begin
      dvd       <= len_sat;
      rem       <= '0;
      div_maxp  <= maxp;
      hold_data <= data_byte;
      hold_len  <= len_sat;
    end else if (state == FR_DIV) begin
      dvd <= {dvd[14:0], q_bit};
      rem <= rem_step;
    end
  end

endmodule

`default_nettype wire

FILE: design/mss_back.sv
`default_nettype none

// Track the open message and tag each byte with its slice header values.
module mss_back (
  input  logic               clk,
  input  logic               rst,
  input  mss_pkg::cmd_t      cmd,
  input  logic               cmd_empty,
  output logic               cmd_pop,
  input  logic [15:0]        maxp,
  input  mss_pkg::id_load_t  id_cfg,
  output logic               res_push,
  output mss_pkg::res_t      res,
  input  logic               res_full
);
  import mss_pkg::*;

  logic [31:0] id_counter, id_counter_next;
  logic [15:0] bytes_remaining, bytes_remaining_next;
  logic [15:0] pos_in_slice, pos_in_slice_next;
  logic [15:0] current_slice, current_slice_next;
  logic [15:0] slices_in_message, slices_in_message_next;
  logic [15:0] tail_payload, tail_payload_next;

  logic        open;
  logic        zero_len;
  logic [15:0] e_brem, e_pos, e_cur, e_slices, e_tail;
  logic [31:0] e_id;
  logic        last_slice;
  logic [15:0] size;
  logic        s_end, m_end;

  assign open     = bytes_remaining != '0;
  assign zero_len = cmd.first && (cmd.len == '0);
  assign cmd_pop  = !cmd_empty && !res_full;
  assign res_push = cmd_pop && !zero_len && (cmd.first || open);

  always_comb begin
    // A first byte restarts the message state; an abandoned message uses up its id.
    e_brem   = cmd.first ? cmd.len    : bytes_remaining;
    e_pos    = cmd.first ? '0         : pos_in_slice;
    e_cur    = cmd.first ? '0         : current_slice;
    e_slices = cmd.first ? cmd.slices : slices_in_message;
    e_tail   = cmd.first ? cmd.tail   : tail_payload;
    e_id     = id_counter + 32'(cmd.first && open);

    last_slice = (17'(e_cur) + 17'd1) >= 17'(e_slices);
    size       = last_slice ? e_tail : maxp;
    m_end      = e_brem == 16'd1;
    s_end      = m_end || ((17'(e_pos) + 17'd1) >= 17'(size));

    res.payload      = cmd.data;
    res.id           = e_id;
    res.slice_number = e_cur;
    res.slice_total  = e_slices;
    res.slice_bytes  = 17'(HEADER_BYTES) + 17'(size);
    res.slice_end    = s_end;
    res.message_end  = m_end;
  end

  always_comb begin
    id_counter_next        = id_counter;
    bytes_remaining_next   = bytes_remaining;
    pos_in_slice_next      = pos_in_slice;
    current_slice_next     = current_slice;
    slices_in_message_next = slices_in_message;
    tail_payload_next      = tail_payload;
    if (id_cfg.load) begin
      id_counter_next = id_cfg.value;
    end else if (cmd_pop && zero_len) begin
      id_counter_next      = e_id + 32'd1;
      bytes_remaining_next = '0;
      pos_in_slice_next    = '0;
      current_slice_next   = '0;
    end else if (res_push) begin
      slices_in_message_next = e_slices;
      tail_payload_next      = e_tail;
      if (m_end) begin
        id_counter_next      = e_id + 32'd1;
        bytes_remaining_next = '0;
        pos_in_slice_next    = '0;
        current_slice_next   = '0;
      end else begin
        id_counter_next      = e_id;
        bytes_remaining_next = e_brem - 16'd1;
        if (s_end) begin
          pos_in_slice_next  = '0;
          current_slice_next = (e_cur == 16'hffff) ? e_cur : e_cur + 16'd1;
        end else begin
          pos_in_slice_next  = e_pos + 16'd1;
          current_slice_next = e_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_counter        <= '0;
      bytes_remaining   <= '0;
      pos_in_slice      <= '0;
      current_slice     <= '0;
      slices_in_message <= '0;
      tail_payload      <= '0;
    end else begin
      id_counter        <= id_counter_next;
      bytes_remaining   <= bytes_remaining_next;
      pos_in_slice      <= pos_in_slice_next;
      current_slice     <= current_slice_next;
      slices_in_message <= slices_in_message_next;
      tail_payload      <= tail_payload_next;
    end
  end

endmodule

`default_nettype wire
